// File: rtl/core/kp200_pkg.sv
package kp200_pkg;

    localparam int unsigned FULL_ROUNDS = 18;
    localparam int unsigned NUM_ROUNDS  = 18;
    localparam int unsigned FIRST_ROUND = FULL_ROUNDS - NUM_ROUNDS;
    localparam int unsigned LANES       = 25;
    localparam int unsigned LANE_W      = 8;

    typedef logic [LANE_W-1:0] t_lane;
    typedef t_lane t_state [LANES];

    localparam t_lane ROUND_CONST [FULL_ROUNDS] = '{
        8'h01, 8'h82, 8'h8A, 8'h00, 8'h8B, 8'h01, 8'h81, 8'h09,
        8'h8A, 8'h88, 8'h09, 8'h0A, 8'h8B, 8'h8B, 8'h89, 8'h03,
        8'h02, 8'h80
    };

    // rotation of lane 5*y+x, taken mod the lane width
    localparam logic [2:0] ROT_AMOUNT [LANES] = '{
        3'd0, 3'd1, 3'd6, 3'd4, 3'd3,
        3'd4, 3'd4, 3'd6, 3'd7, 3'd4,
        3'd3, 3'd2, 3'd3, 3'd1, 3'd7,
        3'd1, 3'd5, 3'd7, 3'd5, 3'd0,
        3'd2, 3'd2, 3'd5, 3'd0, 3'd6
    };

    function automatic t_lane rotl8(input t_lane v, input logic [2:0] k);
        logic [2*LANE_W-1:0] w;
        w = {v, v} << k;
        return w[2*LANE_W-1:LANE_W];
    endfunction

endpackage

// File: rtl/core/kp200_round_stage.sv
module kp200_round_stage
    import kp200_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_state i_state,
    input  t_lane  i_rc,
    output logic   o_valid,
    input  logic   i_ready,
    output t_state o_state
);

    logic   r_valid;
    t_state r_state;
    t_state n_state;
    t_lane  col [5];
    t_lane  dcol [5];
    t_state th;
    t_state pi;

    always_comb begin
        for (int x = 0; x < 5; x++) begin
            col[x] = i_state[x] ^ i_state[5 + x] ^ i_state[10 + x]
                   ^ i_state[15 + x] ^ i_state[20 + x];
        end
        for (int x = 0; x < 5; x++) begin
            dcol[x] = col[(x + 4) % 5] ^ rotl8(col[(x + 1) % 5], 3'd1);
        end
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                th[5 * y + x] = i_state[5 * y + x] ^ dcol[x];
            end
        end
        // relocate A[x,y] to A[y, 2x+3y] after its rotation
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                pi[5 * ((2 * x + 3 * y) % 5) + y] =
                    rotl8(th[5 * y + x], ROT_AMOUNT[5 * y + x]);
            end
        end
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                n_state[5 * y + x] = pi[5 * y + x]
                    ^ (~pi[5 * y + (x + 1) % 5] & pi[5 * y + (x + 2) % 5]);
            end
        end
        n_state[0] = n_state[0] ^ i_rc;
    end

    // advance when this slot is empty or its beat moves on
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

// File: rtl/core/keccak_p200_permutation_unit.sv
// Keccak-p[200] permutation, 18 rounds (Keccak-f[200]), one round per register
// stage. A state enters as 25 byte lanes (byte i of word i/8 at bits 8*(i mod 8),
// lane 24 on its own port) and leaves through the last round register with the
// same packing. A new state is taken every cycle while o_ready is high; the 18
// round registers hold up to 18 states in flight, and each stage takes a new beat
// whenever it is empty or its own beat moves on, so bubbles close up while the
// output is stalled. The sustained rate is one state per cycle while the output
// is not stalled. No state is kept between items.
module keccak_p200_permutation_unit
    import kp200_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_state_bytes_0_7,
    input  logic [63:0] i_state_bytes_8_15,
    input  logic [63:0] i_state_bytes_16_23,
    input  logic [7:0]  i_state_byte_24,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_bytes_0_7,
    output logic [63:0] o_result_bytes_8_15,
    output logic [63:0] o_result_bytes_16_23,
    output logic [7:0]  o_result_byte_24
);

    logic [NUM_ROUNDS:0] vld_chain;
    logic [NUM_ROUNDS:0] rdy_chain;
    t_state              st_chain [NUM_ROUNDS + 1];
    logic [63:0]         in_words [3];
    logic [63:0]         out_words [3];

    assign in_words[0] = i_state_bytes_0_7;
    assign in_words[1] = i_state_bytes_8_15;
    assign in_words[2] = i_state_bytes_16_23;

    for (genvar i = 0; i < LANES - 1; i++) begin : g_unpack
        assign st_chain[0][i] = in_words[i / 8][8 * (i % 8) +: 8];
        assign out_words[i / 8][8 * (i % 8) +: 8] = st_chain[NUM_ROUNDS][i];
    end
    assign st_chain[0][LANES - 1] = i_state_byte_24;

    assign vld_chain[0]          = i_valid;
    assign o_ready               = rdy_chain[0];
    assign rdy_chain[NUM_ROUNDS] = i_ready;
    assign o_valid               = vld_chain[NUM_ROUNDS];

    for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
        kp200_round_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld_chain[r]),
            .o_ready (rdy_chain[r]),
            .i_state (st_chain[r]),
            .i_rc    (ROUND_CONST[FIRST_ROUND + r]),
            .o_valid (vld_chain[r + 1]),
            .i_ready (rdy_chain[r + 1]),
            .o_state (st_chain[r + 1])
        );
    end

    assign o_result_bytes_0_7   = out_words[0];
    assign o_result_bytes_8_15  = out_words[1];
    assign o_result_bytes_16_23 = out_words[2];
    assign o_result_byte_24     = st_chain[NUM_ROUNDS][LANES - 1];

    // input stalls only when every round register holds a beat
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&vld_chain[NUM_ROUNDS:1]))
        else $error("input blocked with a free round slot");

    a_ready_when_empty_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked while output slot empty");

    a_first_stage_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> vld_chain[1])
        else $error("accepted beat not held in first round stage");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(vld_chain[NUM_ROUNDS:1])
             == $past($countones(vld_chain[NUM_ROUNDS:1]))
                + $past(i_valid && o_ready) - $past(o_valid && i_ready)))
        else $error("beat lost or duplicated in round pipeline");

endmodule
